// ===== sv/fresnel_spectral_phase_rotator_defines.svh =====
// ----------------------------------------------------------------------------
// Fresnel phase rotator assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef FRESNEL_SPECTRAL_PHASE_ROTATOR_DEFINES_SVH
`define FRESNEL_SPECTRAL_PHASE_ROTATOR_DEFINES_SVH

// same-cycle implication
`define FSPR_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/fspr_pkg.sv =====
// ----------------------------------------------------------------------------
// Fresnel phase rotator package
// Register indexes and fixed constants of the phase rotator.
// ----------------------------------------------------------------------------
package fspr_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH_IN_USE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT_IN_USE   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CARRIER_TURNS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUAD_COEF_X     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUAD_COEF_Y     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CUTOFF_WEIGHT_X = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CUTOFF_WEIGHT_Y = 3'd6;

   localparam int SIZE_REG_BITS = 11;
   localparam int INDEX_BITS    = 10;
   localparam int TURN_BITS     = 32;

   localparam int GUARD_SHIFT   = 10;
   localparam int CORDIC_STEPS  = 24;
   localparam int GAIN_BITS     = 20;
   localparam logic [GAIN_BITS-1:0] GAIN_Q20 = 20'd636751;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // front stages: fold, square, product, phase, angle
   localparam int FRONT_STAGES = 5;
   localparam int LATENCY      = FRONT_STAGES + CORDIC_STEPS + 2;

   localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

endpackage

// ===== sv/fresnel_spectral_phase_rotator.sv =====
// ----------------------------------------------------------------------------
// Fresnel spectral phase rotator
// Multiplies one FFT bin by the Fresnel transfer function and flags bins
// past the propagation cutoff.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a bin is taken at a rising edge with start high and busy low.
//   busy stays low, so one bin can be transferred every cycle.
//   Output: each result shows on the rsp_ ports for one cycle with rsp_valid
//   high; the receiver has no way to hold it off and must take it then.
//   Throughput is one bin per cycle. The pipeline depth is set by the 24
//   one-step CORDIC stages plus five front stages (fold, square, products,
//   phase, angle) and two stages of gain multiply and round.
//   Configuration: csr_write with csr_index and csr_wdata writes a register
//   at once. Write only when no bin is in flight.
//   Reset clears every valid bit in the pipeline and sets the registers to
//   1024 columns, 1024 rows and zero for the rest.
// ----------------------------------------------------------------------------
module fresnel_spectral_phase_rotator #(
   parameter int MAX_SIZE    = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int PHASE_BITS  = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [fspr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [fspr_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [fspr_pkg::INDEX_BITS-1:0]        req_col_index,
   input  logic [fspr_pkg::INDEX_BITS-1:0]        req_row_index,
   input  logic signed [SAMPLE_BITS-1:0]          req_re_in,
   input  logic signed [SAMPLE_BITS-1:0]          req_im_in,
   output logic                                   rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]          rsp_re_out,
   output logic signed [SAMPLE_BITS-1:0]          rsp_im_out,
   output logic                                   rsp_evanescent
);

   localparam int SB    = fspr_pkg::SIZE_REG_BITS;
   localparam int SW    = ($clog2(MAX_SIZE + 1) > SB) ? $clog2(MAX_SIZE + 1) : SB;
   localparam int KW    = 2 * SW;
   localparam int PW    = fspr_pkg::TURN_BITS + KW;
   localparam int STEPS = fspr_pkg::CORDIC_STEPS;
   localparam int XW    = SAMPLE_BITS + fspr_pkg::GUARD_SHIFT + 2;
   localparam int ZW    = 33;
   localparam int MW    = XW + fspr_pkg::GAIN_BITS + 1;
   localparam int RW    = MW + 1 - 30;
   localparam int LAT   = fspr_pkg::LATENCY;
   localparam int DROP  = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;
   localparam logic [31:0] PH_MASK = 32'hFFFF_FFFF << DROP;
   localparam logic [SW-1:0] MAX_SZ = SW'(MAX_SIZE);
   localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

   // configuration registers
   logic [SB-1:0] width_ff, height_ff;
   logic [31:0]   carrier_ff, coef_x_ff, coef_y_ff, weight_x_ff, weight_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= SB'(1024);
         height_ff   <= SB'(1024);
         carrier_ff  <= '0;
         coef_x_ff   <= '0;
         coef_y_ff   <= '0;
         weight_x_ff <= '0;
         weight_y_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            fspr_pkg::CSR_WIDTH_IN_USE:    width_ff    <= csr_wdata[SB-1:0];
            fspr_pkg::CSR_HEIGHT_IN_USE:   height_ff   <= csr_wdata[SB-1:0];
            fspr_pkg::CSR_CARRIER_TURNS:   carrier_ff  <= csr_wdata;
            fspr_pkg::CSR_QUAD_COEF_X:     coef_x_ff   <= csr_wdata;
            fspr_pkg::CSR_QUAD_COEF_Y:     coef_y_ff   <= csr_wdata;
            fspr_pkg::CSR_CUTOFF_WEIGHT_X: weight_x_ff <= csr_wdata;
            fspr_pkg::CSR_CUTOFF_WEIGHT_Y: weight_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // valid bits and evanescent flag travel with the data
   logic valid_ff [LAT];
   logic evan_ff  [fspr_pkg::FRONT_STAGES - 2 : LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[0] <= start & ~busy;
         for (int i = 1; i < LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // stage 0: fold indexes
   function automatic logic [SW-1:0] fold(input logic [fspr_pkg::INDEX_BITS-1:0] idx,
                                          input logic [SB-1:0] size_reg);
      logic [SW-1:0] size, ix;
      size = SW'(size_reg);
      if (size == '0 || size > MAX_SZ) size = MAX_SZ;
      ix = SW'(idx);
      if (ix <= ((size - SW'(1)) >> 1)) return ix;
      else if (ix >= size)             return ix - size;
      else                             return size - ix;
   endfunction

   logic [SW-1:0] mag_x_ff, mag_y_ff;
   logic signed [SAMPLE_BITS-1:0] re_ff [0:3];
   logic signed [SAMPLE_BITS-1:0] im_ff [0:3];

   always_ff @(posedge clock) begin
      mag_x_ff <= fold(req_col_index, width_ff);
      mag_y_ff <= fold(req_row_index, height_ff);
      re_ff[0] <= req_re_in;
      im_ff[0] <= req_im_in;
      for (int i = 1; i < 4; i++) begin
         re_ff[i] <= re_ff[i-1];
         im_ff[i] <= im_ff[i-1];
      end
   end

   // stage 1: squares
   logic [KW-1:0] kx2_ff, ky2_ff;
   always_ff @(posedge clock) begin
      kx2_ff <= mag_x_ff * mag_x_ff;
      ky2_ff <= mag_y_ff * mag_y_ff;
   end

   // stage 2: coefficient products
   logic [31:0]   px_ff, py_ff;
   logic [PW-1:0] tx_ff, ty_ff;
   logic [PW-1:0] px_in, py_in;
   assign px_in = PW'(coef_x_ff) * PW'(kx2_ff);
   assign py_in = PW'(coef_y_ff) * PW'(ky2_ff);
   always_ff @(posedge clock) begin
      px_ff <= px_in[31:0];
      py_ff <= py_in[31:0];
      tx_ff <= PW'(weight_x_ff) * PW'(kx2_ff);
      ty_ff <= PW'(weight_y_ff) * PW'(ky2_ff);
   end

   // stage 3: phase, quadrant, residual, cutoff
   logic [31:0]        phase_in, resid_in;
   logic [1:0]         quad_in, quad_ff;
   logic signed [31:0] resid_ff;
   logic [PW:0]        tsum_in;
   assign phase_in = (carrier_ff - px_ff - py_ff) & PH_MASK;
   assign quad_in  = phase_in[31:30] + {1'b0, phase_in[29]};
   assign resid_in = phase_in - {quad_in, 30'd0};
   assign tsum_in  = {1'b0, tx_ff} + {1'b0, ty_ff};
   always_ff @(posedge clock) begin
      quad_ff  <= quad_in;
      resid_ff <= $signed(resid_in);
      evan_ff[fspr_pkg::FRONT_STAGES - 2] <= tsum_in > (PW+1)'(64'd1 << 32);
      for (int i = fspr_pkg::FRONT_STAGES - 1; i < LAT; i++) evan_ff[i] <= evan_ff[i-1];
   end

   // stage 4: angle in radians, quarter-turn swap
   logic signed [63:0]       zprod_in;
   logic signed [XW-1:0]     re_x, im_x, x0_in, y0_in;
   logic signed [XW-1:0]     cx_ff [0:STEPS];
   logic signed [XW-1:0]     cy_ff [0:STEPS];
   logic signed [ZW-1:0]     cz_ff [0:STEPS];
   assign zprod_in = resid_ff * $signed({1'b0, fspr_pkg::HALF_PI_Q30});
   assign re_x = XW'(re_ff[3]);
   assign im_x = XW'(im_ff[3]);

   always_comb begin
      unique case (quad_ff)
         2'd1:    begin x0_in = -im_x; y0_in =  re_x; end
         2'd2:    begin x0_in = -re_x; y0_in = -im_x; end
         2'd3:    begin x0_in =  im_x; y0_in = -re_x; end
         default: begin x0_in =  re_x; y0_in =  im_x; end
      endcase
   end

   always_ff @(posedge clock) begin
      cz_ff[0] <= zprod_in[30 +: ZW];
      cx_ff[0] <= x0_in <<< fspr_pkg::GUARD_SHIFT;
      cy_ff[0] <= y0_in <<< fspr_pkg::GUARD_SHIFT;
   end

   // CORDIC, one rotation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_cordic
      logic signed [ZW-1:0] atan_s;
      assign atan_s = $signed(ZW'(fspr_pkg::ATAN_Q30[i]));
      always_ff @(posedge clock) begin
         if (!cz_ff[i][ZW-1]) begin
            cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
            cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
            cz_ff[i+1] <= cz_ff[i] - atan_s;
         end else begin
            cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
            cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
            cz_ff[i+1] <= cz_ff[i] + atan_s;
         end
      end
   end

   // gain multiply, then round and saturate
   logic signed [MW-1:0] gx_ff, gy_ff;
   logic signed [MW:0]   rx_in, ry_in;
   logic signed [RW-1:0] sx_in, sy_in;
   logic signed [SAMPLE_BITS-1:0] re_out_ff, im_out_ff;

   always_ff @(posedge clock) begin
      gx_ff <= MW'(cx_ff[STEPS]) * $signed({1'b0, fspr_pkg::GAIN_Q20});
      gy_ff <= MW'(cy_ff[STEPS]) * $signed({1'b0, fspr_pkg::GAIN_Q20});
   end

   assign rx_in = (MW+1)'(gx_ff) + (MW+1)'(64'sd1 <<< 29);
   assign ry_in = (MW+1)'(gy_ff) + (MW+1)'(64'sd1 <<< 29);
   assign sx_in = rx_in[MW:30];
   assign sy_in = ry_in[MW:30];

   always_ff @(posedge clock) begin
      re_out_ff <= (sx_in > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                   (sx_in < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : sx_in[SAMPLE_BITS-1:0];
      im_out_ff <= (sy_in > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                   (sy_in < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : sy_in[SAMPLE_BITS-1:0];
   end

   assign rsp_valid      = valid_ff[LAT-1];
   assign rsp_re_out     = re_out_ff;
   assign rsp_im_out     = im_out_ff;
   assign rsp_evanescent = evan_ff[LAT-1];

endmodule

// ===== sv/fspr_checker.sv =====
// ----------------------------------------------------------------------------
// Fresnel phase rotator checker
// Port-level assertions on result timing, zero results and busy, bound to the top level.
// ----------------------------------------------------------------------------
`include "fresnel_spectral_phase_rotator_defines.svh"

module fspr_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic signed [SAMPLE_BITS-1:0] req_re_in,
   input logic signed [SAMPLE_BITS-1:0] req_im_in,
   input logic                          rsp_valid,
   input logic signed [SAMPLE_BITS-1:0] rsp_re_out,
   input logic signed [SAMPLE_BITS-1:0] rsp_im_out
);

   `FSPR_ASSERT(a_rsp_has_transfer, rsp_valid, $past(start && !busy, fspr_pkg::LATENCY), "result without a transfer")
   `FSPR_ASSERT(a_zero_in_zero_out, rsp_valid && $past(start && !busy && req_re_in == 0 && req_im_in == 0, fspr_pkg::LATENCY), rsp_re_out == 0 && rsp_im_out == 0, "zero sample not zero")
   `FSPR_ASSERT_NEXT(a_no_busy, 1'b1, !busy, "busy raised")

endmodule

bind fresnel_spectral_phase_rotator fspr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fspr_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_re_in  (req_re_in),
   .req_im_in  (req_im_in),
   .rsp_valid  (rsp_valid),
   .rsp_re_out (rsp_re_out),
   .rsp_im_out (rsp_im_out)
);
